// File: hw/rtl/granule_live_count_table_defines.svh
// ----------------------------------------------------------------------------
// Granule live count table assertion macros
// Concurrent assertion helpers that vanish in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef GRANULE_LIVE_COUNT_TABLE_DEFINES_SVH
`define GRANULE_LIVE_COUNT_TABLE_DEFINES_SVH

`ifndef SYNTHESIS
`define GLCT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define GLCT_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define GLCT_ASSERT(label, prop, msg)
`define GLCT_ASSERT_RST(label, prop, msg)
`endif

`endif

// File: hw/rtl/glct_pkg.sv
// ----------------------------------------------------------------------------
// Granule live count table package
// Shared constants, codes and command/status types.
// ----------------------------------------------------------------------------
package glct_pkg;

  localparam int unsigned Depth    = 1024;
  localparam int unsigned IdxW     = $clog2(Depth);
  localparam int unsigned CapW     = 11;
  localparam int unsigned KeyW     = 64;
  localparam int unsigned CntW     = 32;
  localparam int unsigned StW      = 2;
  localparam int unsigned ReqW     = 2;
  localparam int unsigned HashSteps = 8;

  localparam logic [63:0] MixC1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MixC2 = 64'hc4ceb9fe1a85ec53;

  localparam logic [ReqW-1:0] ReqOpen    = 2'd0;
  localparam logic [ReqW-1:0] ReqClose   = 2'd1;
  localparam logic [ReqW-1:0] ReqAlloc   = 2'd2;
  localparam logic [ReqW-1:0] ReqDealloc = 2'd3;

  localparam logic [StW-1:0] StOk       = 2'd0;
  localparam logic [StW-1:0] StNotFound = 2'd1;
  localparam logic [StW-1:0] StFull     = 2'd2;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;       // capture request, start hash
    logic hash_step;  // advance the hash/modulo unit one step
    logic rd;         // read slot at probe index
    logic step;       // move probe index forward
    logic wr_claim;   // write key, count zero, mark used
    logic wr_inc;
    logic wr_dec;
    logic wr_clear;   // empty slot, latch count
    logic clr;        // clearing sweep write
  } glct_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hash_done;
    logic used;
    logic match;
    logic last_probe;
    logic clr_done;
  } glct_sts_t;

endpackage

// File: hw/rtl/glct_datapath.sv
// ----------------------------------------------------------------------------
// Granule live count table datapath
// Hash unit, remainder unit, probe counter and the slot memories.
// ----------------------------------------------------------------------------
module glct_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  glct_pkg::glct_cmd_t         cmd_i,
  output glct_pkg::glct_sts_t         sts_o,
  input  logic [glct_pkg::KeyW-1:0]   key_i,
  input  logic [glct_pkg::CapW-1:0]   cap_i,
  output logic [glct_pkg::CntW-1:0]   cnt_o
);
  import glct_pkg::*;

  localparam int unsigned EffW = IdxW + 1;
  localparam int unsigned SeqW = $clog2(32 + HashSteps + 1);

  logic [KeyW-1:0] key_q;
  logic [63:0]     h_q, h_d;
  logic [63:0]     acc_q, acc_d;
  logic [SeqW-1:0] seq_q;
  logic [EffW-1:0] cap_q;
  logic [32:0]     rem_q;
  logic [31:0]     quo_q;
  logic [IdxW-1:0] idx_q;
  logic [EffW-1:0] n_q;
  logic [IdxW:0]   clr_q;
  logic [CntW-1:0] cnt_q;

  logic            used_mem [Depth];
  logic [KeyW-1:0] key_mem  [Depth];
  logic [CntW-1:0] cnt_mem  [Depth];
  logic            used_r;
  logic [KeyW-1:0] key_r;
  logic [CntW-1:0] cnt_r;

  logic [EffW-1:0] cap_eff;
  logic [32:0]     rem_sh;
  logic [32:0]     rem_nx;
  logic [63:0]     mix_c;
  logic [31:0]     mul_a, mul_b;
  logic [63:0]     prod;

  always_comb begin
    if (cap_i == '0) begin
      cap_eff = EffW'(1);
    end else if (32'(cap_i) > 32'(Depth)) begin
      cap_eff = EffW'(Depth);
    end else begin
      cap_eff = EffW'(cap_i);
    end
  end

  // Hash sequence: xorshift, mul, xorshift, mul, xorshift, then 32 restoring steps.
  // Each 64-bit multiply keeps the low 64 bits of the product and is built from
  // three 32-bit partial products, taken in turn.
  assign mix_c = (seq_q < SeqW'(5)) ? MixC1 : MixC2;
  assign prod  = mul_a * mul_b;

  always_comb begin
    h_d   = h_q;
    acc_d = acc_q;
    mul_a = h_q[31:0];
    mul_b = mix_c[31:0];
    case (seq_q) inside
      SeqW'(0), SeqW'(4), SeqW'(8): h_d = h_q ^ (h_q >> 33);
      SeqW'(1), SeqW'(5): acc_d = prod;
      SeqW'(2), SeqW'(6): begin
        mul_b = mix_c[63:32];
        acc_d = acc_q + {prod[31:0], 32'd0};
      end
      SeqW'(3), SeqW'(7): begin
        mul_a = h_q[63:32];
        h_d   = acc_q + {prod[31:0], 32'd0};
      end
      default: h_d = h_q;
    endcase
  end

  assign rem_sh = {rem_q[31:0], quo_q[31]};
  assign rem_nx = (rem_sh >= 33'(cap_q)) ? rem_sh - 33'(cap_q) : rem_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.load) begin
        seq_q <= '0;
      end else if (cmd_i.hash_step) begin
        seq_q <= seq_q + SeqW'(1);
      end
      if (cmd_i.clr) begin
        clr_q <= clr_q + (IdxW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= key_i;
      h_q   <= key_i;
      cap_q <= cap_eff;
      rem_q <= '0;
    end else if (cmd_i.hash_step) begin
      if (seq_q <= SeqW'(HashSteps)) begin
        h_q   <= h_d;
        acc_q <= acc_d;
        quo_q <= h_d[31:0];
      end else begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[30:0], 1'b0};
        idx_q <= IdxW'(rem_nx);
      end
      n_q   <= '0;
    end else if (cmd_i.step) begin
      idx_q <= (32'(idx_q) + 1 >= 32'(cap_q)) ? '0 : idx_q + IdxW'(1);
      n_q   <= n_q + EffW'(1);
    end
    if (cmd_i.wr_clear) begin
      cnt_q <= cnt_r;
    end else if (cmd_i.load) begin
      cnt_q <= '0;
    end
  end

  // One-port memories, read data registered.
  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      used_mem[clr_q[IdxW-1:0]] <= 1'b0;
    end else if (cmd_i.wr_claim) begin
      used_mem[idx_q] <= 1'b1;
    end else if (cmd_i.wr_clear) begin
      used_mem[idx_q] <= 1'b0;
    end
    if (cmd_i.rd) begin
      used_r <= used_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_claim) begin
      key_mem[idx_q] <= key_q;
    end
    if (cmd_i.rd) begin
      key_r <= key_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_claim) begin
      cnt_mem[idx_q] <= '0;
    end else if (cmd_i.wr_inc) begin
      cnt_mem[idx_q] <= cnt_r + CntW'(1);
    end else if (cmd_i.wr_dec) begin
      cnt_mem[idx_q] <= cnt_r - CntW'(1);
    end
    if (cmd_i.rd) begin
      cnt_r <= cnt_mem[idx_q];
    end
  end

  assign sts_o.hash_done  = (seq_q == SeqW'(32 + HashSteps));
  assign sts_o.used       = used_r;
  assign sts_o.match      = (key_r == key_q);
  assign sts_o.last_probe = (n_q + EffW'(1) >= cap_q);
  assign sts_o.clr_done   = clr_q[IdxW];
  assign cnt_o            = cnt_q;

endmodule

// File: hw/rtl/glct_ctrl.sv
// ----------------------------------------------------------------------------
// Granule live count table controller
// Sequences clearing, hashing, the probe walk and the result handshake.
// ----------------------------------------------------------------------------
module glct_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [glct_pkg::ReqW-1:0]  req_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [glct_pkg::StW-1:0]   status_o,
  output glct_pkg::glct_cmd_t        cmd_o,
  input  glct_pkg::glct_sts_t        sts_i
);
  import glct_pkg::*;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SHash  = 3'd2;
  localparam logic [2:0] SRead  = 3'd3;
  localparam logic [2:0] SCheck = 3'd4;
  localparam logic [2:0] SDone  = 3'd5;

  logic [2:0]      state_q, state_d;
  logic [ReqW-1:0] req_q;
  logic [StW-1:0]  st_q, st_d;
  logic            ovalid_q, ovalid_d;

  assign in_ready_o  = (state_q == SIdle) && !ovalid_q;
  assign out_valid_o = ovalid_q;
  assign status_o    = st_q;

  always_comb begin
    state_d  = state_q;
    st_d     = st_q;
    ovalid_d = ovalid_q && !out_ready_i;
    cmd_o    = '0;
    unique case (state_q)
      SClear: begin
        cmd_o.clr = !sts_i.clr_done;
        if (sts_i.clr_done) state_d = SIdle;
      end
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.load = 1'b1;
          state_d = SHash;
        end
      end
      SHash: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.hash_done) state_d = SRead;
      end
      SRead: begin
        cmd_o.rd = 1'b1;
        state_d = SCheck;
      end
      SCheck: begin
        state_d = SDone;
        if (!sts_i.used) begin
          if (req_q == ReqOpen) begin
            cmd_o.wr_claim = 1'b1;
            st_d = StOk;
          end else begin
            st_d = StNotFound;
          end
        end else if (sts_i.match) begin
          st_d = StOk;
          cmd_o.wr_clear = (req_q == ReqClose);
          cmd_o.wr_inc   = (req_q == ReqAlloc);
          cmd_o.wr_dec   = (req_q == ReqDealloc);
        end else if (sts_i.last_probe) begin
          st_d = (req_q == ReqOpen) ? StFull : StNotFound;
        end else begin
          cmd_o.step = 1'b1;
          state_d = SRead;
        end
        if (state_d == SDone) ovalid_d = 1'b1;
      end
      SDone: begin
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SClear;
      ovalid_q <= 1'b0;
      st_q     <= StOk;
      req_q    <= ReqOpen;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      st_q     <= st_d;
      if (cmd_o.load) req_q <= req_i;
    end
  end

endmodule

// File: hw/rtl/granule_live_count_table.sv
// ----------------------------------------------------------------------------
// Granule live count table
// Linear-probing hash table of granule ids, each with a live count.
// ----------------------------------------------------------------------------
//  channel | dir | tdata / fields
//  s_axis  | in  | [1:0] req_type, [65:2] id (tdata 72 bits)
//  m_axis  | out | [1:0] status, [33:2] count_out (tdata 40 bits)
//  apb     | cfg | reg 0 capacity at address 0
//
// An item is hashed (each 64-bit multiply runs as three 32-bit partial
// products), reduced by a bit-serial remainder, then probed slot by slot,
// each probe passing through a read state and a check state. The bit-serial
// remainder and the probe walk set the time from one accept to the next.
// After reset a clearing sweep over every slot runs before the first item.
// The next item is taken once the previous result has been accepted.
`include "granule_live_count_table_defines.svh"

module granule_live_count_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // req_type, id, zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // status, count_out, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import glct_pkg::*;

  localparam logic [2:0] AddrCap = 3'd0;

  logic [CapW-1:0] cap_q;
  glct_cmd_t       cmd;
  glct_sts_t       sts;
  logic [StW-1:0]  status;
  logic [CntW-1:0] cnt;

  assign pready = 1'b1;
  assign prdata = (paddr == AddrCap) ? 32'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapW'(Depth);
    end else if (psel && penable && pwrite && paddr == AddrCap) begin
      cap_q <= pwdata[CapW-1:0];
    end
  end

  glct_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .req_i       (s_axis_tdata[1:0]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_o    (status),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  glct_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .key_i (s_axis_tdata[65:2]),
    .cap_i (cap_q),
    .cnt_o (cnt)
  );

  // count_out is nonzero only for a successful close.
  assign m_axis_tdata = {6'd0, (status == StOk) ? cnt : '0, status};

  `GLCT_ASSERT(a_no_accept_busy, m_axis_tvalid |-> !s_axis_tready, "input taken with result pending")
  `GLCT_ASSERT(a_one_write, $onehot0({cmd.wr_claim, cmd.wr_inc, cmd.wr_dec, cmd.wr_clear}), "multiple slot writes")
  `GLCT_ASSERT(a_status_range, m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3), "bad status")
  `GLCT_ASSERT_RST(a_reset_idle, !rst_ni |-> !m_axis_tvalid, "result valid in reset")

endmodule

// File: verif/granule_live_count_table_test.sv
// ----------------------------------------------------------------------------
// Granule live count table testbench
// Sends open, close, alloc and dealloc requests for 64-bit ids under several
// capacity settings. Results are checked against an in-bench copy of the hash
// table or a directed row's expected values, with random idling on both stream sides in most phases.
// ----------------------------------------------------------------------------
module granule_live_count_table_test;
  import glct_pkg::*;

  typedef struct {
    int unsigned     cap;
    logic [ReqW-1:0] req;
    logic [63:0]     id;
    bit              typed;
    logic [StW-1:0]  st;
    logic [31:0]     cnt;
  } dir_row_t;

  typedef struct {
    logic [StW-1:0] st;
    logic [31:0]    cnt;
  } table_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // [1:0] req_type, [65:2] id, zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // [1:0] status, [33:2] count_out, zero pad
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  granule_live_count_table dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Shadow copy of the table.
  bit          slot_live [Depth];
  logic [63:0] slot_id [Depth];
  logic [31:0] slot_cnt [Depth];
  logic [10:0] cap_reg;

  table_result_t pending_results[$];
  int unsigned   err_cnt;
  int unsigned   results_seen;
  bit            idle_on;
  bit            long_hold;
  int unsigned   cap_written;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(input string what);
    err_cnt++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  function automatic logic [31:0] home_hash(input logic [63:0] id);
    logic [63:0] x;
    x = id;
    x = x ^ (x >> 33);
    x = x * 64'hff51afd7ed558ccd;
    x = x ^ (x >> 33);
    x = x * 64'hc4ceb9fe1a85ec53;
    x = x ^ (x >> 33);
    return x[31:0];
  endfunction

  function automatic int unsigned live_cap();
    int unsigned c;
    c = cap_reg;
    if (c == 0) c = 1;
    if (c > Depth) c = Depth;
    return c;
  endfunction

  // Applies one request to the shadow table and returns its result.
  function automatic table_result_t apply_request(input logic [ReqW-1:0] req,
                                                  input logic [63:0] id);
    table_result_t r;
    int unsigned c;
    int unsigned idx;
    int          hit;
    c = live_cap();
    idx = home_hash(id) % c;
    hit = -1;
    r.cnt = '0;
    if (req == ReqOpen) begin
      r.st = StFull;
      for (int unsigned n = 0; n < c; n++) begin
        if (!slot_live[idx]) begin
          slot_live[idx] = 1'b1;
          slot_id[idx] = id;
          slot_cnt[idx] = '0;
          r.st = StOk;
          break;
        end else if (slot_id[idx] == id) begin
          r.st = StOk;
          break;
        end
        idx = (idx + 1 >= c) ? 0 : idx + 1;
      end
    end else begin
      for (int unsigned n = 0; n < c; n++) begin
        if (!slot_live[idx]) break;
        if (slot_id[idx] == id) begin
          hit = idx;
          break;
        end
        idx = (idx + 1 >= c) ? 0 : idx + 1;
      end
      if (hit < 0) begin
        r.st = StNotFound;
      end else begin
        r.st = StOk;
        if (req == ReqClose) begin
          r.cnt = slot_cnt[hit];
          slot_cnt[hit] = '0;
          slot_id[hit] = '0;
          slot_live[hit] = 1'b0;
        end else if (req == ReqAlloc) begin
          slot_cnt[hit] = slot_cnt[hit] + 1;
        end else begin
          slot_cnt[hit] = slot_cnt[hit] - 1;
        end
      end
    end
    return r;
  endfunction

  // Waits for every result plus some settling time, then writes capacity.
  task automatic write_capacity(input int unsigned value);
    wait (pending_results.size() == 0);
    repeat (60) @(posedge clk_i);
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b1; paddr = '0; pwdata = value; penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    cap_reg = value[10:0];
    cap_written++;
  endtask

  task automatic send_request(input logic [ReqW-1:0] req, input logic [63:0] id,
                              input bit typed, input logic [StW-1:0] st,
                              input logic [31:0] cnt);
    int unsigned gap;
    table_result_t r;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = {6'b0, id, req};
    // tready only moves at a rising edge, so its value at the falling edge
    // decides the next rising edge.
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
    r = apply_request(req, id);
    if (typed) begin
      r.st = st;
      r.cnt = cnt;
    end
    pending_results.push_back(r);
  endtask

  // Result side: random stall before each item in idling phases, one long hold on request.
  initial begin
    int unsigned wait_n;
    table_result_t want;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_n = idle_on ? $urandom_range(0, 10) : 0;
      if (long_hold) begin
        wait_n = 400;
        long_hold = 1'b0;
      end
      if (wait_n > 0) begin
        m_axis_tready = 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      m_axis_tready = 1'b1;
      while (!m_axis_tvalid) @(negedge clk_i);
      @(posedge clk_i);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[1:0] !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", m_axis_tdata[1:0], want.st));
        if (m_axis_tdata[33:2] !== want.cnt)
          report_mismatch($sformatf("count %0h, want %0h", m_axis_tdata[33:2], want.cnt));
      end
      @(negedge clk_i);
    end
  end

  initial begin
    dir_row_t    rows[$];
    logic [63:0] pool[16];
    int unsigned caps[9];
    int unsigned k;
    logic [63:0] id;
    logic [ReqW-1:0] req;

    rows = '{
      '{1024, ReqClose,   64'h0, 1, StNotFound, 32'h0},
      '{1024, ReqAlloc,   64'h0, 1, StNotFound, 32'h0},
      '{1024, ReqOpen,    64'h0, 1, StOk, 32'h0},
      '{1024, ReqDealloc, 64'h0, 1, StOk, 32'h0},
      '{1024, ReqClose,   64'h0, 1, StOk, 32'hffffffff},
      '{1024, ReqOpen,    '1, 1, StOk, 32'h0},
      '{1024, ReqAlloc,   '1, 1, StOk, 32'h0},
      '{1024, ReqAlloc,   '1, 1, StOk, 32'h0},
      '{1024, ReqOpen,    '1, 1, StOk, 32'h0},
      '{1024, ReqClose,   '1, 1, StOk, 32'h2},
      '{1024, ReqDealloc, '1, 1, StNotFound, 32'h0},
      '{1, ReqOpen,    64'h5, 1, StOk, 32'h0},
      '{1, ReqOpen,    64'h6, 1, StFull, 32'h0},
      '{1, ReqAlloc,   64'h6, 1, StNotFound, 32'h0},
      '{1, ReqAlloc,   64'h5, 1, StOk, 32'h0},
      '{1, ReqClose,   64'h5, 1, StOk, 32'h1},
      '{1, ReqOpen,    64'h6, 1, StOk, 32'h0},
      '{1, ReqClose,   64'h6, 1, StOk, 32'h0},
      '{0, ReqOpen,    64'h7, 1, StOk, 32'h0},
      '{0, ReqOpen,    64'h8, 1, StFull, 32'h0},
      '{0, ReqClose,   64'h7, 1, StOk, 32'h0},
      '{2047, ReqOpen,  64'ha5a5a5a5a5a5a5a5, 0, StOk, 32'h0},
      '{2047, ReqOpen,  64'h5a5a5a5a5a5a5a5a, 0, StOk, 32'h0},
      '{2047, ReqAlloc, 64'h5a5a5a5a5a5a5a5a, 0, StOk, 32'h0},
      '{2047, ReqClose, 64'ha5a5a5a5a5a5a5a5, 1, StOk, 32'h0}
    };
    caps = '{8, 1, 3, 16, 0, 2047, 2, 64, 1024};

    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    err_cnt = 0; results_seen = 0; cap_written = 0;
    idle_on = 1'b1; long_hold = 1'b0;
    cap_reg = 11'd1024;
    for (int i = 0; i < Depth; i++) begin
      slot_live[i] = 1'b0; slot_id[i] = '0; slot_cnt[i] = '0;
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) begin
      if (rows[i].cap != cap_reg) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        write_capacity(rows[i].cap);
      end
      send_request(rows[i].req, rows[i].id, rows[i].typed, rows[i].st, rows[i].cnt);
    end

    // Random phases: a small id pool per phase keeps hits, chains and
    // breaks after close frequent; a few ids are fresh random values.
    foreach (caps[p]) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      write_capacity(caps[p]);
      idle_on = (p % 3) != 2;
      foreach (pool[j]) pool[j] = {$urandom, $urandom};
      for (int n = 0; n < 170; n++) begin
        if (p == 1 && n == 20) long_hold = 1'b1;
        if (n == 85) wait (pending_results.size() == 0);
        id = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                         : pool[$urandom_range(0, 15)];
        k = $urandom_range(0, 99);
        req = (k < 30) ? ReqOpen : (k < 50) ? ReqClose : (k < 75) ? ReqAlloc : ReqDealloc;
        send_request(req, id, 1'b0, StOk, 32'h0);
      end
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;

    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk_i);
    $display("Covered %0d results over %0d capacity settings, from 0 up to 2047.",
             results_seen, cap_written + 1);
    $display("Requests hit open, full, not found, count wrap and broken probe chains.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/glct_pkg.sv
hw/rtl/glct_datapath.sv
hw/rtl/glct_ctrl.sv
hw/rtl/granule_live_count_table.sv
verif/granule_live_count_table_test.sv
